FILE: sv/fcp_pkg.sv
// ----------------------------------------------------------------------------
// Framed command parser package
// Shared types and constants for the parser front end and executor.
// ----------------------------------------------------------------------------
package fcp_pkg;

    // Result status codes.
    typedef enum logic [3:0] {
        ST_SET      = 4'd0,
        ST_GET      = 4'd1,
        ST_HEADER   = 4'd2,
        ST_LEN_RNG  = 4'd3,
        ST_LEN_MIS  = 4'd4,
        ST_UNKNOWN  = 4'd5,
        ST_BAD_SET  = 4'd6,
        ST_BAD_GET  = 4'd7,
        ST_INDEX    = 4'd8,
        ST_TOO_LONG = 4'd9
    } t_status;

    // Command token matcher states.
    typedef enum logic [2:0] {
        CM_START = 3'd0,
        CM_S     = 3'd1,
        CM_SE    = 3'd2,
        CM_SET   = 3'd3,
        CM_G     = 3'd4,
        CM_GE    = 3'd5,
        CM_GET   = 3'd6,
        CM_NONE  = 3'd7
    } t_cmd;

    // Number parser phases.
    typedef enum logic [1:0] {
        NP_LEAD  = 2'd0,
        NP_DIGIT = 2'd1,
        NP_SPARE = 2'd2,
        NP_DONE  = 2'd3
    } t_nphase;

    // Operation that the front end hands to the executor.
    typedef enum logic [1:0] {
        OP_REPORT = 2'd0,
        OP_WRITE  = 2'd1,
        OP_READ   = 2'd2
    } t_op;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Header characters by position.
    function automatic logic [7:0] hdr_char(input logic [1:0] p);
        case (p)
            2'd0:    hdr_char = 8'h66;
            2'd1:    hdr_char = 8'h63;
            2'd2:    hdr_char = 8'h6f;
            default: hdr_char = 8'h6d;
        endcase
    endfunction

    // Command matcher step.
    function automatic t_cmd cmd_next(input t_cmd s, input logic [7:0] c);
        case (s)
            CM_START: cmd_next = (c == 8'h73) ? CM_S : ((c == 8'h67) ? CM_G : CM_NONE);
            CM_S:     cmd_next = (c == 8'h65) ? CM_SE : CM_NONE;
            CM_SE:    cmd_next = (c == 8'h74) ? CM_SET : CM_NONE;
            CM_G:     cmd_next = (c == 8'h65) ? CM_GE : CM_NONE;
            CM_GE:    cmd_next = (c == 8'h74) ? CM_GET : CM_NONE;
            default:  cmd_next = CM_NONE;
        endcase
    endfunction

endpackage

FILE: sv/framed_command_parser.sv
// ----------------------------------------------------------------------------
// Framed command parser
// Parses zero-terminated "fcom" frames and executes set/get on a table.
// ----------------------------------------------------------------------------
// Input channel: a byte word is accepted when push is high and full low.
// Non-zero bytes produce no result; each zero byte ends a frame and produces
// one result word.
// Result channel: while empty is low the oldest result is on the o_ ports;
// it is taken when pop is high. Results queue in a four-entry queue.
// Throughput: one byte per cycle while full is low. A terminator reaches
// empty low through front classification, table read and queue write.
// When the receiver stalls, full rises once two results wait, leaving room
// for commands still in flight between the front end and the queue.
// Reset clears all frame state, empties the queue and clears the table
// through per-entry valid bits at once.
// ----------------------------------------------------------------------------
module framed_command_parser import fcp_pkg::*; #(
    parameter int TABLE_DEPTH = 64,
    parameter int MAX_FRAME   = 255,
    parameter int VALUE_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [7:0]            i_rx_byte,
    output logic                  empty,
    input  logic                  pop,
    output logic [3:0]            o_status,
    output logic [7:0]            o_declared_length,
    output logic [8:0]            o_measured_length,
    output logic [VALUE_BITS-1:0] o_entry_index,
    output logic [VALUE_BITS-1:0] o_entry_value
);

    localparam int IDX_BITS = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic                  f_valid;
    t_op                   f_op;
    t_status               f_status;
    logic [7:0]            f_decl;
    logic [8:0]            f_meas;
    logic [VALUE_BITS-1:0] f_idx, f_val;
    logic [IDX_BITS-1:0]   f_addr;
    logic                  almost_full;

    fcp_front #(
        .TABLE_DEPTH(TABLE_DEPTH), .MAX_FRAME(MAX_FRAME),
        .VALUE_BITS(VALUE_BITS), .IDX_BITS(IDX_BITS)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(push && !full), .i_byte(i_rx_byte),
        .o_valid(f_valid), .o_op(f_op), .o_status(f_status),
        .o_decl(f_decl), .o_meas(f_meas), .o_idx(f_idx),
        .o_val(f_val), .o_addr(f_addr)
    );

    fcp_back #(
        .TABLE_DEPTH(TABLE_DEPTH), .VALUE_BITS(VALUE_BITS), .IDX_BITS(IDX_BITS)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(f_valid), .i_op(f_op), .i_status(f_status),
        .i_decl(f_decl), .i_meas(f_meas), .i_idx(f_idx),
        .i_val(f_val), .i_addr(f_addr), .i_pop(pop),
        .o_empty(empty), .o_almost_full(almost_full),
        .o_status(o_status), .o_decl(o_declared_length),
        .o_meas(o_measured_length), .o_idx(o_entry_index),
        .o_val(o_entry_value)
    );

    assign full = almost_full;

endmodule

FILE: sv/fcp_front.sv
// ----------------------------------------------------------------------------
// Framed command parser front end
// Parses one byte per cycle and emits one classified command per frame.
// ----------------------------------------------------------------------------
module fcp_front import fcp_pkg::*; #(
    parameter int TABLE_DEPTH = 64,
    parameter int MAX_FRAME   = 255,
    parameter int VALUE_BITS  = 16,
    parameter int IDX_BITS    = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [7:0]            i_byte,
    output logic                  o_valid,
    output t_op                   o_op,
    output t_status               o_status,
    output logic [7:0]            o_decl,
    output logic [8:0]            o_meas,
    output logic [VALUE_BITS-1:0] o_idx,
    output logic [VALUE_BITS-1:0] o_val,
    output logic [IDX_BITS-1:0]   o_addr
);

    logic [7:0]            r_pos;
    logic                  r_too_long;
    logic                  r_hdr_ok;
    logic [7:0]            r_len;
    logic [3:0]            r_tok_cnt;
    logic                  r_in_tok;
    t_cmd                  r_cmd;
    t_nphase               r_ph  [2];
    logic                  r_neg [2];
    logic [VALUE_BITS-1:0] r_acc [2];

    logic                  is_digit;
    logic [VALUE_BITS-1:0] digit_v;
    logic [3:0]            tok_after;
    logic [VALUE_BITS-1:0] idx_v, val_v;
    logic [8:0]            meas;
    logic                  idx_ok;

    assign is_digit  = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign digit_v   = VALUE_BITS'(i_byte - CH_ZERO);
    assign tok_after = (!r_in_tok && r_tok_cnt != 4'd15) ? r_tok_cnt + 4'd1 : r_tok_cnt;
    assign idx_v     = r_neg[0] ? (~r_acc[0] + 1'b1) : r_acc[0];
    assign val_v     = r_neg[1] ? (~r_acc[1] + 1'b1) : r_acc[1];
    assign meas      = {1'b0, r_pos} + 9'd1;
    assign idx_ok    = !idx_v[VALUE_BITS-1] &&
                       ({1'b0, idx_v} < (VALUE_BITS+1)'(TABLE_DEPTH));

    // Frame state update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && i_byte == 8'd0)) begin
            r_pos      <= '0;
            r_too_long <= 1'b0;
            r_hdr_ok   <= 1'b1;
            r_len      <= '0;
            r_tok_cnt  <= '0;
            r_in_tok   <= 1'b0;
            r_cmd      <= CM_START;
            for (int k = 0; k < 2; k++) begin
                r_ph[k]  <= NP_LEAD;
                r_neg[k] <= 1'b0;
                r_acc[k] <= '0;
            end
        end else if (i_valid) begin
            if (r_pos < 8'd4) begin
                if (i_byte != hdr_char(r_pos[1:0])) r_hdr_ok <= 1'b0;
            end else if (r_pos == 8'd4) begin
                r_len <= i_byte;
            end else if (i_byte == CH_SPACE) begin
                r_in_tok <= 1'b0;
            end else begin
                r_in_tok  <= 1'b1;
                r_tok_cnt <= tok_after;
                if (tok_after == 4'd1) begin
                    r_cmd <= cmd_next(r_cmd, i_byte);
                end
                for (int k = 0; k < 2; k++) begin
                    if (tok_after == 4'(k + 2)) begin
                        if (r_ph[k] == NP_LEAD) begin
                            if (i_byte >= 8'd9 && i_byte <= 8'd13) begin
                                r_ph[k] <= NP_LEAD;
                            end else if (i_byte == CH_PLUS) begin
                                r_ph[k] <= NP_DIGIT;
                            end else if (i_byte == CH_MINUS) begin
                                r_ph[k]  <= NP_DIGIT;
                                r_neg[k] <= 1'b1;
                            end else if (is_digit) begin
                                r_ph[k]  <= NP_DIGIT;
                                r_acc[k] <= digit_v;
                            end else begin
                                r_ph[k] <= NP_DONE;
                            end
                        end else if (r_ph[k] == NP_DIGIT) begin
                            if (is_digit) begin
                                r_acc[k] <= VALUE_BITS'({r_acc[k], 3'b000}
                                          + {r_acc[k], 1'b0} + digit_v);
                            end else begin
                                r_ph[k] <= NP_DONE;
                            end
                        end
                    end
                end
            end
            if (r_pos >= 8'(MAX_FRAME - 1)) r_too_long <= 1'b1;
            if (r_pos != 8'd255) r_pos <= r_pos + 8'd1;
        end
    end

    // Classification at the terminator.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid && i_byte == 8'd0;
        end
        o_decl <= r_len;
        o_meas <= meas;
        o_idx  <= '0;
        o_val  <= '0;
        o_addr <= idx_v[IDX_BITS-1:0];
        o_op   <= OP_REPORT;
        if (r_too_long) begin
            o_status <= ST_TOO_LONG;
        end else if (r_pos < 8'd4 || !r_hdr_ok) begin
            o_status <= ST_HEADER;
        end else if (r_len < 8'd5 || {1'b0, r_len} > 9'(MAX_FRAME)) begin
            o_status <= ST_LEN_RNG;
        end else if (meas != {1'b0, r_len}) begin
            o_status <= ST_LEN_MIS;
        end else if (r_tok_cnt == 4'd0 || (r_cmd != CM_SET && r_cmd != CM_GET)) begin
            o_status <= ST_UNKNOWN;
        end else if (r_cmd == CM_SET) begin
            if (r_tok_cnt != 4'd3) begin
                o_status <= ST_BAD_SET;
            end else begin
                o_idx <= idx_v;
                if (!idx_ok) begin
                    o_status <= ST_INDEX;
                end else begin
                    o_status <= ST_SET;
                    o_val    <= val_v;
                    o_op     <= OP_WRITE;
                end
            end
        end else begin
            if (r_tok_cnt != 4'd2) begin
                o_status <= ST_BAD_GET;
            end else begin
                o_idx <= idx_v;
                if (!idx_ok) begin
                    o_status <= ST_INDEX;
                end else begin
                    o_status <= ST_GET;
                    o_op     <= OP_READ;
                end
            end
        end
    end

endmodule

FILE: sv/fcp_back.sv
// ----------------------------------------------------------------------------
// Framed command parser executor
// Holds the variable table and a result queue; performs set and get.
// ----------------------------------------------------------------------------
module fcp_back import fcp_pkg::*; #(
    parameter int TABLE_DEPTH = 64,
    parameter int VALUE_BITS  = 16,
    parameter int IDX_BITS    = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  t_op                   i_op,
    input  t_status               i_status,
    input  logic [7:0]            i_decl,
    input  logic [8:0]            i_meas,
    input  logic [VALUE_BITS-1:0] i_idx,
    input  logic [VALUE_BITS-1:0] i_val,
    input  logic [IDX_BITS-1:0]   i_addr,
    input  logic                  i_pop,
    output logic                  o_empty,
    output logic                  o_almost_full,
    output logic [3:0]            o_status,
    output logic [7:0]            o_decl,
    output logic [8:0]            o_meas,
    output logic [VALUE_BITS-1:0] o_idx,
    output logic [VALUE_BITS-1:0] o_val
);

    localparam int QD = 4;

    // Table with per-entry valid bits so reset reads as zero.
    logic [VALUE_BITS-1:0]  r_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_vld;
    logic [VALUE_BITS-1:0]  r_rd;
    logic                   r_rd_vld;

    // Stage holding the command during the table read.
    logic                   r_s_v;
    t_op                    r_s_op;
    t_status                r_s_st;
    logic [7:0]             r_s_decl;
    logic [8:0]             r_s_meas;
    logic [VALUE_BITS-1:0]  r_s_idx, r_s_val;

    // Result queue.
    logic [3:0]            r_q_st   [QD];
    logic [7:0]            r_q_decl [QD];
    logic [8:0]            r_q_meas [QD];
    logic [VALUE_BITS-1:0] r_q_idx  [QD];
    logic [VALUE_BITS-1:0] r_q_val  [QD];
    logic [1:0]            r_wp, r_rp;
    logic [2:0]            r_cnt;
    logic                  push_q, pop_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_valid && i_op == OP_WRITE) begin
            r_vld[i_addr] <= 1'b1;
        end
        if (i_valid && i_op == OP_WRITE) r_mem[i_addr] <= i_val;
        r_rd     <= r_mem[i_addr];
        r_rd_vld <= r_vld[i_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_v <= 1'b0;
        end else begin
            r_s_v <= i_valid;
        end
        r_s_op   <= i_op;
        r_s_st   <= i_status;
        r_s_decl <= i_decl;
        r_s_meas <= i_meas;
        r_s_idx  <= i_idx;
        r_s_val  <= i_val;
    end

    assign push_q = r_s_v;
    assign pop_q  = i_pop && (r_cnt != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_q) r_wp <= r_wp + 2'd1;
            if (pop_q)  r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'b0, push_q} - {2'b0, pop_q};
        end
        if (push_q) begin
            r_q_st[r_wp]   <= r_s_st;
            r_q_decl[r_wp] <= r_s_decl;
            r_q_meas[r_wp] <= r_s_meas;
            r_q_idx[r_wp]  <= r_s_idx;
            r_q_val[r_wp]  <= (r_s_op == OP_READ) ? (r_rd_vld ? r_rd : '0) : r_s_val;
        end
    end

    // Two commands may be in flight ahead of the queue.
    assign o_almost_full = r_cnt >= 3'd2;
    assign o_empty  = r_cnt == 3'd0;
    assign o_status = r_q_st[r_rp];
    assign o_decl   = r_q_decl[r_rp];
    assign o_meas   = r_q_meas[r_rp];
    assign o_idx    = r_q_idx[r_rp];
    assign o_val    = r_q_val[r_rp];

endmodule

FILE: tb/tb_framed_command_parser.sv
// ----------------------------------------------------------------------------
// Framed command parser testbench
// Sends byte words that form command frames, predicts the result word of each
// terminator with a model of the parser and its table, and checks every
// result word field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_framed_command_parser import fcp_pkg::*;;

    localparam int DEPTH    = 64;
    localparam int MAXFRAME = 255;

    typedef struct packed {
        logic [3:0]  status;
        logic [7:0]  decl_len;
        logic [8:0]  meas_len;
        logic [15:0] index;
        logic [15:0] value;
    } t_reply;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [7:0]  i_rx_byte;
    logic        empty;
    logic        pop;
    logic [3:0]  o_status;
    logic [7:0]  o_declared_length;
    logic [8:0]  o_measured_length;
    logic [15:0] o_entry_index;
    logic [15:0] o_entry_value;

    t_reply pending_replies[$];
    int     error_count;
    bit     hold_off;
    bit     no_idle;

    // Model state of the parser.
    logic [7:0]  m_pos;
    logic        m_too_long;
    logic        m_hdr_ok;
    logic [7:0]  m_len_byte;
    logic [3:0]  m_tokens;
    logic        m_in_token;
    t_cmd        m_cmd;
    t_nphase     m_phase[2];
    logic        m_neg[2];
    logic [15:0] m_acc[2];
    logic [15:0] m_table[DEPTH];

    framed_command_parser u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_rx_byte(i_rx_byte), .empty(empty), .pop(pop), .o_status(o_status),
        .o_declared_length(o_declared_length), .o_measured_length(o_measured_length),
        .o_entry_index(o_entry_index), .o_entry_value(o_entry_value)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Return the frame state to its idle values.
    task automatic clear_frame_model();
        m_pos = '0;
        m_too_long = 1'b0;
        m_hdr_ok = 1'b1;
        m_len_byte = '0;
        m_tokens = '0;
        m_in_token = 1'b0;
        m_cmd = CM_START;
        for (int k = 0; k < 2; k++) begin
            m_phase[k] = NP_LEAD;
            m_neg[k] = 1'b0;
            m_acc[k] = '0;
        end
    endtask

    // Next command matcher state for one character.
    function automatic t_cmd match_step(t_cmd s, logic [7:0] c);
        case (s)
            CM_START: return (c == "s") ? CM_S : ((c == "g") ? CM_G : CM_NONE);
            CM_S:     return (c == "e") ? CM_SE : CM_NONE;
            CM_SE:    return (c == "t") ? CM_SET : CM_NONE;
            CM_G:     return (c == "e") ? CM_GE : CM_NONE;
            CM_GE:    return (c == "t") ? CM_GET : CM_NONE;
            default:  return CM_NONE;
        endcase
    endfunction

    // Feed one character to the decimal number parser k.
    task automatic number_step(int k, logic [7:0] c);
        bit digit;
        digit = (c >= "0" && c <= "9");
        if (m_phase[k] == NP_LEAD) begin
            if (c >= 8'd9 && c <= 8'd13) begin
                return;
            end
            if (c == "+") begin
                m_phase[k] = NP_DIGIT;
            end else if (c == "-") begin
                m_neg[k] = 1'b1;
                m_phase[k] = NP_DIGIT;
            end else if (digit) begin
                m_acc[k] = 16'(c - "0");
                m_phase[k] = NP_DIGIT;
            end else begin
                m_phase[k] = NP_DONE;
            end
        end else if (m_phase[k] == NP_DIGIT) begin
            if (digit) begin
                m_acc[k] = 16'(m_acc[k] * 10 + (c - "0"));
            end else begin
                m_phase[k] = NP_DONE;
            end
        end
    endtask

    // Predict the effect of one accepted byte word; a terminator queues a reply.
    task automatic predict_byte(logic [7:0] c);
        t_reply      r;
        logic [15:0] idx;
        if (c == 8'd0) begin
            r = '0;
            r.decl_len = m_len_byte;
            r.meas_len = 9'(m_pos) + 9'd1;
            idx = m_neg[0] ? 16'(-m_acc[0]) : m_acc[0];
            if (m_too_long) begin
                r.status = ST_TOO_LONG;
            end else if (m_pos < 4 || !m_hdr_ok) begin
                r.status = ST_HEADER;
            end else if (m_len_byte < 5) begin
                r.status = ST_LEN_RNG;
            end else if (r.meas_len != 9'(m_len_byte)) begin
                r.status = ST_LEN_MIS;
            end else if (m_tokens == 0 || (m_cmd != CM_SET && m_cmd != CM_GET)) begin
                r.status = ST_UNKNOWN;
            end else if (m_cmd == CM_SET && m_tokens != 3) begin
                r.status = ST_BAD_SET;
            end else if (m_cmd == CM_GET && m_tokens != 2) begin
                r.status = ST_BAD_GET;
            end else begin
                r.index = idx;
                if (idx[15] || idx >= DEPTH) begin
                    r.status = ST_INDEX;
                end else if (m_cmd == CM_SET) begin
                    r.status = ST_SET;
                    r.value = m_neg[1] ? 16'(-m_acc[1]) : m_acc[1];
                    m_table[idx] = r.value;
                end else begin
                    r.status = ST_GET;
                    r.value = m_table[idx];
                end
            end
            pending_replies.push_back(r);
            clear_frame_model();
            return;
        end
        if (m_pos < 4) begin
            if (c != 8'("fcom" >> (8 * (3 - m_pos)))) begin
                m_hdr_ok = 1'b0;
            end
        end else if (m_pos == 4) begin
            m_len_byte = c;
        end else if (c == " ") begin
            m_in_token = 1'b0;
        end else begin
            if (!m_in_token) begin
                m_in_token = 1'b1;
                if (m_tokens < 15) begin
                    m_tokens++;
                end
            end
            if (m_tokens == 1) begin
                m_cmd = match_step(m_cmd, c);
            end else if (m_tokens == 2) begin
                number_step(0, c);
            end else if (m_tokens == 3) begin
                number_step(1, c);
            end
        end
        if (m_pos >= MAXFRAME - 1) begin
            m_too_long = 1'b1;
        end
        if (m_pos < 255) begin
            m_pos++;
        end
    endtask

    // Send one byte word, after a random idle gap, and wait for its acceptance.
    task automatic send_byte(logic [7:0] c);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        repeat (gap) @(negedge i_clk);
        push = 1'b1;
        i_rx_byte = c;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_byte(c);
        @(negedge i_clk);
        push = 1'b0;
    endtask

    // Send a frame: header, a length byte and the body, then the terminator.
    task automatic send_frame(string body, int len_adj = 0, bit bad_hdr = 0);
        string hdr;
        hdr = bad_hdr ? "fcon" : "fcom";
        for (int i = 0; i < 4; i++) send_byte(hdr[i]);
        send_byte(8'(body.len() + 6 + len_adj));
        for (int i = 0; i < body.len(); i++) send_byte(body[i]);
        send_byte(8'd0);
    endtask

    task automatic wait_drained();
        while (pending_replies.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Receiver: random pop stalls, plus an external long hold-off.
    initial begin
        int gap;
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            gap = no_idle ? 0 : $urandom_range(0, 10);
            pop = 1'b0;
            repeat (gap) @(negedge i_clk);
            while (hold_off) @(negedge i_clk);
            pop = 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
        end
    end

    // Compare each accepted result word with the oldest prediction.
    always @(posedge i_clk) begin
        t_reply got, want;
        if (i_rst_n && pop && !empty) begin
            got = {o_status, o_declared_length, o_measured_length,
                   o_entry_index, o_entry_value};
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected result word, actual %h", $time, got);
                error_count++;
            end else begin
                want = pending_replies.pop_front();
                if (got.status !== want.status)
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, got.status);
                if (got.decl_len !== want.decl_len)
                    $display("%0t: declared_length expected %0d actual %0d", $time,
                             want.decl_len, got.decl_len);
                if (got.meas_len !== want.meas_len)
                    $display("%0t: measured_length expected %0d actual %0d", $time,
                             want.meas_len, got.meas_len);
                if (got.index !== want.index)
                    $display("%0t: entry_index expected %0d actual %0d", $time,
                             $signed(want.index), $signed(got.index));
                if (got.value !== want.value)
                    $display("%0t: entry_value expected %0d actual %0d", $time,
                             $signed(want.value), $signed(got.value));
                if (got !== want) error_count++;
            end
        end
    end

    // Header, length and command checks with set/get on the table edges.
    task automatic test_directed();
        send_frame("set 0 32767");
        send_frame("set 63 -32768");
        send_frame("get 63");
        send_frame("get 0");
        send_frame("get 5");
        send_frame("set 64 1");
        send_frame("get -1");
        send_frame("set 1 70000");
        send_frame("get +1");
        send_frame("get 1", 1);
        send_frame("get 1", 0, 1);
        send_frame("put 1");
        send_frame("");
        send_frame("set 1");
        send_frame("get 1 2");
        send_frame("set  \t 2 x 5 6 7 8 9 1 2 3 4 5 6 7 8 9");
        send_frame("set 3 12ab");
        send_byte("f");
        send_byte(8'd0);
        send_byte(8'd0);
        for (int i = 0; i < 4; i++) send_byte(8'("fcom" >> (8 * (3 - i))));
        send_byte(8'd3);
        send_byte(8'd0);
        wait_drained();
    endtask

    // A frame of maximum length and one that runs past it.
    task automatic test_long_frames();
        string s;
        s = "set 7 ";
        while (s.len() < 249) s = {s, "1"};
        send_frame(s);
        s = {s, "1111111111111"};
        send_frame(s);
        send_frame("get 7");
        wait_drained();
    endtask

    // Receiver holds off while frames keep coming, so the input stalls.
    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (200) @(negedge i_clk);
                hold_off = 1'b0;
            end
            begin
                no_idle = 1'b1;
                repeat (6) send_frame("get 2");
                no_idle = 1'b0;
            end
        join
        wait_drained();
    endtask

    // Random frames: mostly well-formed commands, some noise.
    task automatic test_random();
        int    sent;
        string body;
        byte   b;
        sent = 0;
        while (sent < 400) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    body = $sformatf("set %0d %0d", int'($urandom_range(0, 70)) - 3,
                                     $signed(16'($urandom)));
                    send_frame(body, ($urandom_range(0, 9) == 0) ? 1 : 0);
                end
                4, 5, 6: send_frame($sformatf("get %0d", $urandom_range(0, 66)));
                7: begin
                    body = "";
                    repeat ($urandom_range(0, 12)) begin
                        b = byte'($urandom_range(1, 255));
                        body = {body, string'(b)};
                    end
                    send_frame(body, 0, $urandom_range(0, 1));
                end
                default: begin
                    repeat ($urandom_range(0, 8)) send_byte(8'($urandom_range(1, 255)));
                    send_byte(8'd0);
                end
            endcase
            sent += 12;
            if ($urandom_range(0, 30) == 0) no_idle = ~no_idle;
        end
        no_idle = 1'b0;
        wait_drained();
    endtask

    initial begin
        error_count = 0;
        hold_off = 1'b0;
        no_idle = 1'b0;
        push = 1'b0;
        i_rx_byte = '0;
        i_rst_n = 1'b0;
        clear_frame_model();
        for (int i = 0; i < DEPTH; i++) m_table[i] = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_long_frames();
        test_backpressure();
        test_random();
        repeat (20) @(negedge i_clk);
        if (error_count == 0 && pending_replies.size() == 0) begin
            $display("tb_framed_command_parser passed");
        end else begin
            $display("tb_framed_command_parser failed");
        end
        $finish;
    end

    // Run limit well beyond the slowest correct run.
    initial begin
        #20ms;
        $display("tb_framed_command_parser failed");
        $finish;
    end

endmodule
